/* rtl/lte_eea2_ctr_stream_cipher_top_defines.svh */
// assertion macros shared by the cipher rtl
// no dependencies
`ifndef LTE_EEA2_CTR_STREAM_CIPHER_TOP_DEFINES_SVH
`define LTE_EEA2_CTR_STREAM_CIPHER_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define EEA2_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same check, also active during reset
`define EEA2_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/eea2_pkg.sv */
// package for the eea2 counter mode cipher: types, constants, aes helpers
// no dependencies
package eea2_pkg;
  localparam int BLOCK_INDEX_BITS = 16;
  localparam int AES_ROUNDS = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_KEY_HIGH = 3'd0;
  localparam cfg_idx_t REG_KEY_LOW = 3'd1;
  localparam cfg_idx_t REG_FRAME_COUNT = 3'd2;
  localparam cfg_idx_t REG_BEARER_ID = 3'd3;
  localparam cfg_idx_t REG_DIRECTION = 3'd4;
  localparam cfg_idx_t REG_START_OFFSET = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_ROUND,
    ST_OUT
  } state_t;

  // core control and status
  typedef struct packed {
    logic start;
  } aes_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } aes_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input logic [127:0] b, input int i);
    return b[127-8*i -: 8];
  endfunction
endpackage

/* rtl/eea2_if.sv */
// valid/ready stream interface carrying a generic payload type
// depends on nothing
interface eea2_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/eea2_aes_core.sv */
// iterative aes-128 encryption: one round and one key expansion step per cycle
// depends on eea2_pkg
module eea2_aes_core import eea2_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  aes_ctrl_t    ctrl,
  input  logic [127:0] key,
  input  logic [127:0] block_in,
  output aes_stat_t    stat,
  output logic [127:0] block_out
);
  logic [127:0] st;
  logic [127:0] rk;
  logic [7:0]   rc;
  logic [3:0]   round;
  logic         busy;
  logic         done;
  logic [127:0] rk_next;
  logic [127:0] st_next;
  logic [127:0] sub;
  logic [127:0] mix;
  logic [31:0]  w;
  logic [31:0]  w0, w1, w2, w3;

  // next round key
  always_comb begin
    w = {sbox(rk[23:16]) ^ rc, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
    w0 = rk[127:96] ^ w;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    rk_next = {w0, w1, w2, w3};
  end

  // subbytes, shiftrows, mixcolumns (not in the last round), addroundkey
  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sub[127-8*(i+4*c) -: 8] = sbox(byte_of(st, i + 4 * ((c + i) & 3)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(sub, 4*c);
      a1 = byte_of(sub, 4*c+1);
      a2 = byte_of(sub, 4*c+2);
      a3 = byte_of(sub, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mix[127-32*c -: 32] = {a0 ^ al ^ xt(a0 ^ a1), a1 ^ al ^ xt(a1 ^ a2),
                             a2 ^ al ^ xt(a2 ^ a3), a3 ^ al ^ xt(a3 ^ a0)};
    end
    st_next = ((round == 4'(AES_ROUNDS)) ? sub : mix) ^ rk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      round <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        round <= 4'd1;
      end else if (busy) begin
        round <= round + 4'd1;
        if (round == 4'(AES_ROUNDS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      st <= block_in ^ key;
      rk <= key;
      rc <= 8'h01;
    end else if (busy) begin
      st <= st_next;
      rk <= rk_next;
      rc <= xt(rc);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign block_out = st;
endmodule

/* rtl/lte_eea2_ctr_stream_cipher_top.sv */
// byte stream aes-128 counter mode cipher for lte eea2
// accept in ST_IDLE, then ST_START, then ST_OUT if the keystream block is cached;
//   else ST_START starts aes and ST_ROUND waits (10 aes rounds on one shared round unit)
// one byte in flight: in_ch is ready again only after ST_OUT hands the result over
// rst is synchronous, active high: position, cache valid and config registers go to zero
// depends on eea2_pkg, eea2_if, eea2_aes_core and the defines header
`include "lte_eea2_ctr_stream_cipher_top_defines.svh"
module lte_eea2_ctr_stream_cipher_top import eea2_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  eea2_if.sink                  in_ch,
  eea2_if.source                out_ch
);
  // configuration registers
  logic [63:0] key_high, key_low;
  logic [31:0] frame_count;
  logic [4:0]  bearer_id;
  logic        direction;
  logic [15:0] start_offset_bytes;

  // stream position and keystream cache
  logic [BLOCK_INDEX_BITS-1:0] blk_index;
  logic [3:0]   blk_byte;
  logic [127:0] ks;
  logic         ks_valid;

  // held beat
  logic [7:0] data;
  logic       last;

  state_t state, state_next;
  aes_ctrl_t aes_ctrl;
  aes_stat_t aes_stat;
  logic [127:0] aes_out;
  logic [127:0] ctr;
  logic [7:0]   ks_byte;

  // counter block: count, bearer/dir, zeros, index in the low bits
  always_comb begin
    ctr = '0;
    ctr[127:96] = frame_count;
    ctr[95:88] = {bearer_id, direction, 2'b00};
    ctr[BLOCK_INDEX_BITS-1:0] = blk_index;
  end

  eea2_aes_core u_aes (
    .clk(clk), .rst(rst), .ctrl(aes_ctrl), .key({key_high, key_low}),
    .block_in(ctr), .stat(aes_stat), .block_out(aes_out)
  );

  assign ks_byte = ks[127 - {blk_byte, 3'b000} -: 8];

  always_comb begin
    state_next = state;
    aes_ctrl.start = 1'b0;
    unique case (state)
      ST_IDLE: if (in_ch.valid) state_next = ST_START;
      ST_START: begin
        // position already updated for a first beat
        if (ks_valid) begin
          state_next = ST_OUT;
        end else begin
          aes_ctrl.start = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: if (aes_stat.done) state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.payload.out_byte = data ^ ks_byte;
  assign out_ch.payload.out_last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      frame_count <= '0;
      bearer_id <= '0;
      direction <= 1'b0;
      start_offset_bytes <= '0;
      blk_index <= '0;
      blk_byte <= '0;
      ks_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_KEY_HIGH: key_high <= cfg_data;
          REG_KEY_LOW: key_low <= cfg_data;
          REG_FRAME_COUNT: frame_count <= cfg_data[31:0];
          REG_BEARER_ID: bearer_id <= cfg_data[4:0];
          REG_DIRECTION: direction <= cfg_data[0];
          REG_START_OFFSET: start_offset_bytes <= cfg_data[15:0];
          default: ;
        endcase
        if (cfg_idx <= REG_START_OFFSET) ks_valid <= 1'b0;
      end
      if (in_ch.valid && in_ch.ready && in_ch.payload.first_of_message) begin
        blk_index <= BLOCK_INDEX_BITS'(start_offset_bytes[15:4]);
        blk_byte <= start_offset_bytes[3:0];
        ks_valid <= 1'b0;
      end
      if (aes_stat.done) ks_valid <= 1'b1;
      if (out_ch.valid && out_ch.ready) begin
        blk_byte <= blk_byte + 4'd1;
        if (blk_byte == 4'hf) begin
          blk_index <= blk_index + 1'b1;
          ks_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data <= in_ch.payload.data_byte;
      last <= in_ch.payload.last_of_message;
    end
    if (aes_stat.done) ks <= aes_out;
  end

  `EEA2_ASSERT(a_done_in_round, clk, rst, aes_stat.done |-> state == ST_ROUND, "aes done outside round wait")
  `EEA2_ASSERT(a_out_has_ks, clk, rst, out_ch.valid |-> ks_valid, "result shown without keystream")
  `EEA2_ASSERT(a_busy_round, clk, rst, aes_stat.busy |-> state == ST_ROUND, "aes busy outside round wait")
  `EEA2_ASSERT_ALWAYS(a_rst_idle, clk, $past(rst) |-> state == ST_IDLE, "state not idle after reset")
endmodule
